// ===== hdl/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types, constants and controller/datapath command and status records
// for the sync/length/CRC frame extractor.
// ----------------------------------------------------------------------------
package slcd_pkg;

	// Default size of the receive byte buffer
	localparam int BUF_BYTES_DEF = 64;

	// Frame layout: sync pair, length lo/hi, type, sequence, then payload
	localparam int HDR_BYTES      = 6;
	localparam int OVERHEAD_BYTES = 8;
	localparam int LEN_LO_OFS     = 2;
	localparam int LEN_HI_OFS     = 3;
	localparam int TYPE_OFS       = 4;
	localparam int SEQ_OFS        = 5;

	// CRC-16, MSB first
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_MAX_PAYLOAD = 2'd2
	} cfg_reg_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_HDR_RD,
		S_HDR_USE,
		S_CRC_RD,
		S_CRC_XOR,
		S_CRC_BIT,
		S_CHK_LO_RD,
		S_CHK_LO,
		S_CHK_HI_RD,
		S_CHK_HI,
		S_EMIT_RD,
		S_EMIT_LD,
		S_OUT_WAIT
	} state_t;

	// Offset counter operations
	typedef enum logic [2:0] {
		K_HOLD,
		K_ZERO,
		K_TWO,
		K_SIX,
		K_INC
	} k_op_t;

	// Amount removed from the front of the buffer
	typedef enum logic [2:0] {
		DROP_NONE,
		DROP_SCAN,
		DROP_ONE,
		DROP_FRAME,
		DROP_KEEP_LAST
	} drop_t;

	typedef struct packed {
		logic   wr_byte;
		k_op_t  k_op;
		drop_t  drop;
		logic   prev_capture;
		logic   hdr_capture;
		logic   crc_init;
		logic   crc_load;
		logic   crc_step;
		logic   lo_capture;
		logic   out_load;
		logic   out_empty;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_lt_hdr;
		logic sync_hit;
		logic k_is_one;
		logic scan_end;
		logic hdr_done;
		logic len_over;
		logic frame_short;
		logic k_at_end;
		logic bit_last;
		logic crc_ok;
		logic len_zero;
		logic out_taken;
		logic out_last;
	} dp_sts_t;

endpackage

// ===== hdl/slcd_ram.sv =====
// ----------------------------------------------------------------------------
// slcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/slcd_dp.sv =====
// ----------------------------------------------------------------------------
// slcd_dp
// Datapath: circular byte buffer, offset counter, header capture, bit-serial
// CRC-16, configuration registers and the result output register.
// ----------------------------------------------------------------------------
module slcd_dp #(
	parameter int BUFFER_BYTES = slcd_pkg::BUF_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  slcd_pkg::dp_cmd_t                  cmd,
	output slcd_pkg::dp_sts_t                  sts,
	input  logic                               cfg_we,
	input  logic [slcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slcd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [7:0]                         rx_byte,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [5:0]                         frame_len,
	output logic [7:0]                         frame_type,
	output logic [7:0]                         frame_seq,
	output logic [7:0]                         payload_byte,
	output logic                               byte_valid,
	output logic                               frame_end
);
	import slcd_pkg::*;

	localparam int AW        = $clog2(BUFFER_BYTES);
	localparam int FW        = $clog2(BUFFER_BYTES + 1);
	localparam int LIMIT_CAP = BUFFER_BYTES - OVERHEAD_BYTES;

	logic [7:0]    sync_first_q;
	logic [7:0]    sync_second_q;
	logic [5:0]    max_payload_q;
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] k_q;
	logic [FW-1:0] drop_n;
	logic [7:0]    prev_q;
	logic [15:0]   len_q;
	logic [7:0]    type_q;
	logic [7:0]    seq_q;
	logic [15:0]   crc_q;
	logic [2:0]    bit_q;
	logic [7:0]    lo_q;
	logic [5:0]    limit;
	logic [7:0]    rd_data;
	logic          ram_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          out_valid_q;
	logic [5:0]    frame_len_q;
	logic [7:0]    frame_type_q;
	logic [7:0]    frame_seq_q;
	logic [7:0]    payload_byte_q;
	logic          byte_valid_q;
	logic          frame_end_q;

	// Add an offset to a buffer position and wrap around the buffer
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [FW-1:0] off);
		logic [FW:0] sum;
		sum = {{(FW + 1 - AW){1'b0}}, base} + {1'b0, off};
		if (sum >= (FW + 1)'(BUFFER_BYTES)) begin
			sum = sum - (FW + 1)'(BUFFER_BYTES);
		end
		return sum[AW-1:0];
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= 8'hAA;
			sync_second_q <= 8'h55;
			max_payload_q <= 6'd56;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign limit = (max_payload_q > 6'(LIMIT_CAP)) ? 6'(LIMIT_CAP) : max_payload_q;

	// Byte buffer
	assign ram_we = cmd.wr_byte && (fill_q < FW'(BUFFER_BYTES));
	assign waddr  = wrap_add(head_q, fill_q);
	assign raddr  = wrap_add(head_q, k_q);

	slcd_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (rx_byte),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Select how many bytes leave the front of the buffer
	always_comb begin
		case (cmd.drop)
			DROP_SCAN:      drop_n = k_q - FW'(1);
			DROP_ONE:       drop_n = FW'(1);
			DROP_FRAME:     drop_n = FW'(len_q) + FW'(OVERHEAD_BYTES);
			DROP_KEEP_LAST: drop_n = fill_q - FW'(1);
			default:        drop_n = '0;
		endcase
	end

	// Buffer head and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ram_we) begin
			fill_q <= fill_q + FW'(1);
		end else if (cmd.drop != DROP_NONE) begin
			head_q <= wrap_add(head_q, drop_n);
			fill_q <= fill_q - drop_n;
		end
	end

	// Offset counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else begin
			case (cmd.k_op)
				K_ZERO:  k_q <= '0;
				K_TWO:   k_q <= FW'(LEN_LO_OFS);
				K_SIX:   k_q <= FW'(HDR_BYTES);
				K_INC:   k_q <= k_q + FW'(1);
				default: k_q <= k_q;
			endcase
		end
	end

	// Scan byte, header fields and CRC low byte
	always_ff @(posedge clk) begin
		if (cmd.prev_capture) begin
			prev_q <= rd_data;
		end
		if (cmd.lo_capture) begin
			lo_q <= rd_data;
		end
		if (cmd.hdr_capture) begin
			case (k_q)
				FW'(LEN_LO_OFS): len_q[7:0]  <= rd_data;
				FW'(LEN_HI_OFS): len_q[15:8] <= rd_data;
				FW'(TYPE_OFS):   type_q      <= rd_data;
				default:         seq_q       <= rd_data;
			endcase
		end
	end

	// Bit-serial CRC, one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.crc_init) begin
			crc_q <= CRC_INIT;
		end else if (cmd.crc_load) begin
			crc_q <= crc_q ^ {rd_data, 8'h00};
			bit_q <= '0;
		end else if (cmd.crc_step) begin
			if ((crc_q & CRC_MSB) != 16'h0000) begin
				crc_q <= {crc_q[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc_q <= {crc_q[14:0], 1'b0};
			end
			bit_q <= bit_q + 3'd1;
		end
	end

	// Result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			frame_len_q  <= len_q[5:0];
			frame_type_q <= type_q;
			frame_seq_q  <= seq_q;
			if (cmd.out_empty) begin
				payload_byte_q <= 8'h00;
				byte_valid_q   <= 1'b0;
				frame_end_q    <= 1'b1;
			end else begin
				payload_byte_q <= rd_data;
				byte_valid_q   <= 1'b1;
				frame_end_q    <= sts.k_at_end;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_len    = frame_len_q;
	assign frame_type   = frame_type_q;
	assign frame_seq    = frame_seq_q;
	assign payload_byte = payload_byte_q;
	assign byte_valid   = byte_valid_q;
	assign frame_end    = frame_end_q;

	// Status back to the controller
	always_comb begin
		sts.fill_lt_hdr = fill_q < FW'(HDR_BYTES);
		sts.sync_hit    = (k_q != '0) && (prev_q == sync_first_q) &&
			(rd_data == sync_second_q);
		sts.k_is_one    = k_q == FW'(1);
		sts.scan_end    = ({1'b0, k_q} + (FW + 1)'(1)) >= {1'b0, fill_q};
		sts.hdr_done    = k_q == FW'(SEQ_OFS);
		sts.len_over    = len_q > 16'(limit);
		sts.frame_short = ({1'b0, len_q} + 17'(OVERHEAD_BYTES)) > 17'(fill_q);
		sts.k_at_end    = 17'(k_q) == ({1'b0, len_q} + 17'(HDR_BYTES - 1));
		sts.bit_last    = bit_q == 3'd7;
		sts.crc_ok      = crc_q == {rd_data, lo_q};
		sts.len_zero    = len_q == 16'h0000;
		sts.out_taken   = out_valid_q && !out_stall;
		sts.out_last    = frame_end_q;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(BUFFER_BYTES))
		else $error("fill count beyond buffer size");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < AW'(BUFFER_BYTES - 1) || head_q == AW'(BUFFER_BYTES - 1))
		else $error("buffer head out of range");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("result shown without a load");

	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_byte |-> cmd.drop == DROP_NONE)
		else $error("byte write and buffer drop in one cycle");

endmodule

// ===== hdl/slcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// slcd_ctrl
// Controller: takes a byte, then scans, checks and delivers every complete
// frame in the buffer before taking the next byte.
// ----------------------------------------------------------------------------
module slcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  slcd_pkg::dp_sts_t sts,
	output slcd_pkg::dp_cmd_t cmd
);
	import slcd_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.k_op = K_HOLD;
		cmd.drop = DROP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.wr_byte = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.fill_lt_hdr) begin
					state_d = S_IDLE;
				end else begin
					cmd.k_op = K_ZERO;
					state_d  = S_SRCH_RD;
				end
			end
			S_SRCH_RD: state_d = S_SRCH_CMP;
			S_SRCH_CMP: begin
				if (sts.sync_hit) begin
					if (sts.k_is_one) begin
						cmd.k_op = K_TWO;
						state_d  = S_HDR_RD;
					end else begin
						cmd.drop = DROP_SCAN;
						state_d  = S_CHECK;
					end
				end else if (sts.scan_end) begin
					cmd.drop = DROP_KEEP_LAST;
					state_d  = S_IDLE;
				end else begin
					cmd.prev_capture = 1'b1;
					cmd.k_op         = K_INC;
					state_d          = S_SRCH_RD;
				end
			end
			S_HDR_RD: state_d = S_HDR_USE;
			S_HDR_USE: begin
				cmd.hdr_capture = 1'b1;
				if (!sts.hdr_done) begin
					cmd.k_op = K_INC;
					state_d  = S_HDR_RD;
				end else if (sts.len_over) begin
					cmd.drop = DROP_ONE;
					state_d  = S_CHECK;
				end else if (sts.frame_short) begin
					state_d = S_IDLE;
				end else begin
					cmd.crc_init = 1'b1;
					cmd.k_op     = K_TWO;
					state_d      = S_CRC_RD;
				end
			end
			S_CRC_RD: state_d = S_CRC_XOR;
			S_CRC_XOR: begin
				cmd.crc_load = 1'b1;
				state_d      = S_CRC_BIT;
			end
			S_CRC_BIT: begin
				cmd.crc_step = 1'b1;
				if (sts.bit_last) begin
					cmd.k_op = K_INC;
					state_d  = sts.k_at_end ? S_CHK_LO_RD : S_CRC_RD;
				end
			end
			S_CHK_LO_RD: state_d = S_CHK_LO;
			S_CHK_LO: begin
				cmd.lo_capture = 1'b1;
				cmd.k_op       = K_INC;
				state_d        = S_CHK_HI_RD;
			end
			S_CHK_HI_RD: state_d = S_CHK_HI;
			S_CHK_HI: begin
				if (!sts.crc_ok) begin
					cmd.drop = DROP_ONE;
					state_d  = S_CHECK;
				end else if (sts.len_zero) begin
					cmd.out_load  = 1'b1;
					cmd.out_empty = 1'b1;
					state_d       = S_OUT_WAIT;
				end else begin
					cmd.k_op = K_SIX;
					state_d  = S_EMIT_RD;
				end
			end
			S_EMIT_RD: state_d = S_EMIT_LD;
			S_EMIT_LD: begin
				cmd.out_load = 1'b1;
				state_d      = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				if (sts.out_taken) begin
					if (sts.out_last) begin
						cmd.drop = DROP_FRAME;
						state_d  = S_CHECK;
					end else begin
						cmd.k_op = K_INC;
						state_d  = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_crc_only_when_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CRC_BIT |-> !sts.out_taken)
		else $error("result transfer during CRC check");

endmodule

// ===== hdl/sync_length_crc_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_crc_deframer
// Byte-stream frame extractor: sync pair, 16-bit length, type, sequence,
// payload and CRC-16 (0x1021, init 0xFFFF), one result per payload byte.
// ----------------------------------------------------------------------------
// One received byte is taken per input transfer; the block then stalls its
// input until every complete frame in the buffer has been checked and
// delivered. After reset no clearing pass is needed. Each taken byte is
// written and the fill checked; each byte searched for the sync pair and
// each header byte is read, then compared or captured. Each CRC-covered
// byte (length, type, sequence and payload) is read, XORed in and shifted
// bit by bit, the CRC unit advancing one bit per cycle; the received CRC
// is read low byte first. Each result is fetched, loaded and held through
// any output stall; the single read port fetches one payload byte at a
// time. A bad length or CRC drops one byte and restarts the search.
// ----------------------------------------------------------------------------
module sync_length_crc_deframer #(
	parameter int BUFFER_BYTES = slcd_pkg::BUF_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [slcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [5:0]                      frame_len,
	output logic [7:0]                      frame_type,
	output logic [7:0]                      frame_seq,
	output logic [7:0]                      payload_byte,
	output logic                            byte_valid,
	output logic                            frame_end
);
	import slcd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	slcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Buffer, CRC and result register
	slcd_dp #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.frame_len    (frame_len),
		.frame_type   (frame_type),
		.frame_seq    (frame_seq),
		.payload_byte (payload_byte),
		.byte_valid   (byte_valid),
		.frame_end    (frame_end)
	);

endmodule
